@@ hw/rtl/qkd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qkd_pkg: shared types and constants for the quadrature knob decoder
// phase codes of the A/B tracker, step codes and the reset press gap
// ----------------------------------------------------------------------------
package qkd_pkg;

  localparam int unsigned GAP_W  = 31;
  localparam int unsigned TIME_W = 32;

  typedef logic [2:0]        phase_t;
  typedef logic [1:0]        turn_t;
  typedef logic [1:0]        ab_t;
  typedef logic [GAP_W-1:0]  gap_t;
  typedef logic [TIME_W-1:0] time_t;

  localparam phase_t PH_REST = 3'd0;
  localparam phase_t PH_UP1  = 3'd1;
  localparam phase_t PH_UP2  = 3'd2;
  localparam phase_t PH_UP3  = 3'd3;
  localparam phase_t PH_DN1  = 3'd4;
  localparam phase_t PH_DN2  = 3'd5;
  localparam phase_t PH_DN3  = 3'd6;

  localparam turn_t TURN_NONE = 2'd0;
  localparam turn_t TURN_UP   = 2'd1;
  localparam turn_t TURN_DOWN = 2'd2;

  localparam ab_t AB_00   = 2'd0;
  localparam ab_t AB_01   = 2'd1;
  localparam ab_t AB_10   = 2'd2;
  localparam ab_t AB_REST = 2'd3;

  localparam gap_t GAP_RESET = 31'd1000000;

  localparam int unsigned SWITCH_BIT = 2;

endpackage

@@ hw/rtl/quadrature_knob_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrature_knob_decoder: push switch debounce and quadrature step decoder
// one pin sample with timestamp in, one press/turn item out
// ----------------------------------------------------------------------------
// Takes one item per clock while the output is not stalled and returns
// exactly one result item per input item. Each item passes an input
// register, then the press-gap compare (one 32-bit subtract and a 31-bit
// compare) and the phase tracker update, then the result register. The
// phase and last press time are updated as the item leaves the input
// register, so back-to-back items see each other's state. A stalled
// output holds one result and one more item in the input register before
// in_ready drops. The user writes press_gap through the cfg port only
// while idle; the block itself does not enforce this.
module quadrature_knob_decoder (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [2:0]      in_pins,
  input  qkd_pkg::time_t  in_now,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_press,
  output qkd_pkg::turn_t  out_turn,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  qkd_pkg::gap_t   cfg_press_gap
);
  import qkd_pkg::*;

  // input register
  logic       s1_valid_r;
  logic [2:0] pins_r;
  time_t      now_r;

  // state and config
  gap_t  gap_r;
  time_t last_press_r;

  // result register
  logic  out_valid_r;
  logic  out_press_r;
  turn_t out_turn_r;

  logic  s2_ready;
  logic  s1_fire;
  time_t diff;
  logic  press_ok;
  turn_t turn_c;

  assign s2_ready = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && s2_ready;
  assign in_ready = !s1_valid_r || s2_ready;
  assign cfg_ready = 1'b1;

  assign diff     = now_r - last_press_r;
  assign press_ok = pins_r[SWITCH_BIT] && !diff[TIME_W-1] && (diff[GAP_W-1:0] > gap_r);

  qkd_phase u_phase (
    .clk  (clk),
    .rst_n(rst_n),
    .en   (s1_fire),
    .ab   (pins_r[1:0]),
    .turn (turn_c)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pins_r <= in_pins;
      now_r  <= in_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r        <= GAP_RESET;
      last_press_r <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        gap_r <= cfg_press_gap;
      end
      if (s1_fire && press_ok) begin
        last_press_r <= now_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_press_r <= press_ok;
      out_turn_r  <= turn_c;
    end
  end

  assign out_valid = out_valid_r;
  assign out_press = out_press_r;
  assign out_turn  = out_turn_r;

`ifndef SYNTHESIS
  a_press_stores_time: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && press_ok) |=> last_press_r == $past(now_r))
    else $error("accepted press did not store its time");

  a_time_moves_on_press: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && last_press_r != $past(last_press_r)) |-> $past(s1_fire && press_ok))
    else $error("last press time changed without a press");

  a_stalled_item_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s2_ready) |=> (s1_valid_r && $stable(now_r) && $stable(pins_r)))
    else $error("item in input register lost during stall");

  a_result_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r)
    else $error("item left input register without a result");
`endif

endmodule

@@ hw/rtl/qkd_phase.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qkd_phase: seven-state quadrature phase tracker
// follows the A/B code and flags one step when a full sequence returns to rest
// ----------------------------------------------------------------------------
module qkd_phase (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  qkd_pkg::ab_t ab,
  output qkd_pkg::turn_t turn
);
  import qkd_pkg::*;

  phase_t phase_r;
  phase_t phase_nxt;
  turn_t  turn_c;

  always_comb begin
    phase_nxt = phase_r;
    turn_c    = TURN_NONE;
    case (phase_r)
      PH_REST: begin
        if (ab == AB_01) phase_nxt = PH_UP1;
        else if (ab == AB_10) phase_nxt = PH_DN1;
      end
      PH_UP1: begin
        if (ab == AB_00) phase_nxt = PH_UP2;
        else if (ab == AB_REST) phase_nxt = PH_REST;
      end
      PH_UP2: begin
        if (ab == AB_10) phase_nxt = PH_UP3;
        else if (ab == AB_01) phase_nxt = PH_UP1;
      end
      PH_UP3: begin
        if (ab == AB_REST) begin
          phase_nxt = PH_REST;
          turn_c    = TURN_UP;
        end else if (ab == AB_00) begin
          phase_nxt = PH_UP2;
        end
      end
      PH_DN1: begin
        if (ab == AB_00) phase_nxt = PH_DN2;
        else if (ab == AB_REST) phase_nxt = PH_REST;
      end
      PH_DN2: begin
        if (ab == AB_01) phase_nxt = PH_DN3;
        else if (ab == AB_10) phase_nxt = PH_DN1;
      end
      PH_DN3: begin
        if (ab == AB_REST) begin
          phase_nxt = PH_REST;
          turn_c    = TURN_DOWN;
        end else if (ab == AB_00) begin
          phase_nxt = PH_DN2;
        end
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_REST;
    end else if (en) begin
      phase_r <= phase_nxt;
    end
  end

  assign turn = turn_c;

`ifndef SYNTHESIS
  a_step_ends_at_rest: assert property (@(posedge clk) disable iff (!rst_n)
    (en && turn_c != TURN_NONE) |=> phase_r == PH_REST)
    else $error("step reported without return to rest");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(phase_r))
    else $error("phase moved without an item");

  a_step_on_rest_code: assert property (@(posedge clk) disable iff (!rst_n)
    turn_c != TURN_NONE |-> ab == AB_REST)
    else $error("step reported on a non-rest code");
`endif

endmodule

@@ sim/tb_quadrature_knob_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quadrature_knob_decoder: self-checking bench for the knob decoder
// a directed table covers gap limits, wrapped timestamps and both step
// directions. It is followed by random gestures with bounces and noise
// under several press gaps. Every result item is checked against a local
// tracker model or, for typed table rows, against the typed expectation.
// Both sides stall at random except in the last phase, with one long output hold-off.
module tb_quadrature_knob_decoder;
  import qkd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 40;
  localparam int unsigned PHASE_ITEMS = 280;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef struct packed {
    logic  press;
    turn_t turn;
  } knob_out_t;

  typedef struct {
    logic [2:0] pins;
    time_t      now;
    bit         typed;
    logic       press;
    turn_t      turn;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] in_pins = '0;
  time_t      in_now = '0;
  logic       out_valid;
  logic       out_ready = 1'b1;
  logic       out_press;
  turn_t      out_turn;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  gap_t       cfg_press_gap = '0;

  // expectation typed into the table, carried along with the item
  bit         row_typed = 1'b0;
  logic       row_press = 1'b0;
  turn_t      row_turn = TURN_NONE;

  bit          tx_stalls = 1'b1;
  bit          rx_stalls = 1'b1;
  bit          hold_off_req = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  int unsigned phase_items = 0;
  int unsigned time_step_max = 0;
  time_t       clock_now = '0;

  // tracker model
  phase_t      trk_phase;
  time_t       trk_last_press;
  gap_t        trk_gap;
  knob_out_t   pending_q[$];

  dir_row_t dir_rows [25] = '{
    '{{1'b0, AB_REST}, 32'd0,          1'b1, 1'b0, TURN_NONE},
    '{{1'b1, AB_REST}, 32'd1000000,    1'b1, 1'b0, TURN_NONE},
    '{{1'b1, AB_REST}, 32'd1000001,    1'b1, 1'b1, TURN_NONE},
    '{{1'b1, AB_01},   32'hFFFF_FFFF,  1'b1, 1'b0, TURN_NONE},
    '{{1'b0, AB_00},   32'd0,          1'b0, 1'b0, TURN_NONE},
    '{{1'b0, AB_10},   32'd0,          1'b0, 1'b0, TURN_NONE},
    '{{1'b1, AB_REST}, 32'd2000002,    1'b1, 1'b1, TURN_UP},
    '{{1'b0, AB_10},   32'd0,          1'b0, 1'b0, TURN_NONE},
    '{{1'b0, AB_00},   32'd0,          1'b0, 1'b0, TURN_NONE},
    '{{1'b0, AB_01},   32'd0,          1'b0, 1'b0, TURN_NONE},
    '{{1'b0, AB_REST}, 32'd0,          1'b1, 1'b0, TURN_DOWN},
    '{{1'b0, AB_01},   32'd0,          1'b0, 1'b0, TURN_NONE},
    '{{1'b0, AB_10},   32'd0,          1'b0, 1'b0, TURN_NONE},
    '{{1'b0, AB_REST}, 32'd0,          1'b1, 1'b0, TURN_NONE},
    '{{1'b0, AB_01},   32'd0,          1'b0, 1'b0, TURN_NONE},
    '{{1'b0, AB_00},   32'd0,          1'b0, 1'b0, TURN_NONE},
    '{{1'b0, AB_01},   32'd0,          1'b0, 1'b0, TURN_NONE},
    '{{1'b0, AB_00},   32'd0,          1'b0, 1'b0, TURN_NONE},
    '{{1'b0, AB_10},   32'd0,          1'b0, 1'b0, TURN_NONE},
    '{{1'b0, AB_00},   32'd0,          1'b0, 1'b0, TURN_NONE},
    '{{1'b0, AB_10},   32'd0,          1'b0, 1'b0, TURN_NONE},
    '{{1'b0, AB_REST}, 32'd0,          1'b1, 1'b0, TURN_UP},
    '{{1'b1, AB_00},   32'h801E_8482,  1'b1, 1'b0, TURN_NONE},
    '{{1'b1, AB_00},   32'h801E_8481,  1'b1, 1'b1, TURN_NONE},
    '{{1'b1, AB_REST}, 32'h801E_8481,  1'b1, 1'b0, TURN_NONE}
  };

  quadrature_knob_decoder u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pins       (in_pins),
    .in_now        (in_now),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_press     (out_press),
    .out_turn      (out_turn),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_press_gap (cfg_press_gap)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // press gap check and phase tracker for one sample
  function automatic knob_out_t decode_sample(logic [2:0] pins, time_t now);
    knob_out_t r;
    time_t     diff;
    ab_t       ab;
    r.press = 1'b0;
    r.turn  = TURN_NONE;
    ab      = pins[1:0];
    if (pins[SWITCH_BIT]) begin
      diff = now - trk_last_press;
      if (!diff[TIME_W-1] && diff[GAP_W-1:0] > trk_gap) begin
        trk_last_press = now;
        r.press = 1'b1;
      end
    end
    case (trk_phase)
      PH_REST: begin
        if (ab == AB_01) trk_phase = PH_UP1;
        else if (ab == AB_10) trk_phase = PH_DN1;
      end
      PH_UP1: begin
        if (ab == AB_00) trk_phase = PH_UP2;
        else if (ab == AB_REST) trk_phase = PH_REST;
      end
      PH_UP2: begin
        if (ab == AB_10) trk_phase = PH_UP3;
        else if (ab == AB_01) trk_phase = PH_UP1;
      end
      PH_UP3: begin
        if (ab == AB_REST) begin
          r.turn = TURN_UP;
          trk_phase = PH_REST;
        end else if (ab == AB_00) trk_phase = PH_UP2;
      end
      PH_DN1: begin
        if (ab == AB_00) trk_phase = PH_DN2;
        else if (ab == AB_REST) trk_phase = PH_REST;
      end
      PH_DN2: begin
        if (ab == AB_01) trk_phase = PH_DN3;
        else if (ab == AB_10) trk_phase = PH_DN1;
      end
      PH_DN3: begin
        if (ab == AB_REST) begin
          r.turn = TURN_DOWN;
          trk_phase = PH_REST;
        end else if (ab == AB_00) trk_phase = PH_DN2;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    knob_out_t want;
    knob_out_t got;
    if (!rst_n) begin
      trk_phase      = PH_REST;
      trk_last_press = '0;
      trk_gap        = GAP_RESET;
      pending_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) trk_gap = cfg_press_gap;
      if (in_valid && in_ready) begin
        want = decode_sample(in_pins, in_now);
        if (row_typed) begin
          want.press = row_press;
          want.turn  = row_turn;
        end
        pending_q.push_back(want);
      end
      if (out_valid && out_ready) begin
        got.press = out_press;
        got.turn  = out_turn;
        if (pending_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result item: press=%0b turn=%0d", out_press, out_turn);
        end else begin
          want = pending_q.pop_front();
          if (got.press !== want.press || got.turn !== want.turn) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected press=%0b turn=%0d, got press=%0b turn=%0d",
                       want.press, want.turn, got.press, got.turn);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("** quadrature_knob_decoder: FAILED **");
      $finish;
    end
  end

  // output side: short random stalls and one long hold-off on request
  initial begin : receiver
    int n;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        out_ready <= 1'b1;
      end else if (rx_stalls && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  task automatic offer_item(logic [2:0] pins, time_t now, bit typed, logic press, turn_t turn);
    in_valid  <= 1'b1;
    in_pins   <= pins;
    in_now    <= now;
    row_typed <= typed;
    row_press <= press;
    row_turn  <= turn;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (tx_stalls && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_press_gap(gap_t gap);
    wait_drained();
    cfg_valid     <= 1'b1;
    cfg_press_gap <= gap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic time_t next_stamp();
    if ($urandom_range(0, 9) == 0) clock_now = $urandom;
    else clock_now = clock_now + $urandom_range(0, time_step_max);
    return clock_now;
  endfunction

  task automatic send_ab(ab_t ab);
    logic sw;
    sw = ($urandom_range(0, 2) == 0);
    offer_item({sw, ab}, next_stamp(), 1'b0, 1'b0, TURN_NONE);
    phase_items++;
  endtask

  // one detent worth of A/B codes with contact bounce, or plain noise
  task automatic send_gesture();
    ab_t path [4];
    int  kind;
    int  i;
    kind = $urandom_range(0, 9);
    if (kind < 8) begin
      if (kind < 4) path = '{AB_01, AB_00, AB_10, AB_REST};
      else path = '{AB_10, AB_00, AB_01, AB_REST};
      for (i = 0; i < 4; i++) begin
        repeat ($urandom_range(1, 3)) send_ab(path[i]);
        if (i > 0 && i < 3 && $urandom_range(0, 7) == 0) begin
          send_ab(path[i-1]);
          send_ab(path[i]);
        end
        if (i < 3 && $urandom_range(0, 19) == 0) send_ab(ab_t'($urandom_range(0, 3)));
      end
    end else begin
      repeat ($urandom_range(1, 6)) send_ab(ab_t'($urandom_range(0, 3)));
    end
  endtask

  task automatic run_phase(gap_t gap, int unsigned step_max, bit long_hold);
    bit held;
    held = 1'b0;
    program_press_gap(gap);
    time_step_max = step_max;
    phase_items = 0;
    while (phase_items < PHASE_ITEMS) begin
      if (long_hold && !held && phase_items >= 50) begin
        hold_off_req = 1'b1;
        held = 1'b1;
      end
      send_gesture();
    end
  endtask

  initial begin : stimulus
    int i;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < 25; i++)
      offer_item(dir_rows[i].pins, dir_rows[i].now, dir_rows[i].typed,
                 dir_rows[i].press, dir_rows[i].turn);

    run_phase(gap_t'(0), 3, 1'b1);
    run_phase({GAP_W{1'b1}}, 32'h7FFF_FFFF, 1'b0);
    run_phase(gap_t'($urandom_range(1, 2000)), 1000, 1'b0);
    run_phase(gap_t'($urandom), 32'h4000_0000, 1'b0);
    tx_stalls = 1'b0;
    rx_stalls = 1'b0;
    run_phase(GAP_RESET, 600000, 1'b0);

    wait_drained();
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("** quadrature_knob_decoder: PASSED **");
    end else begin
      $display("** quadrature_knob_decoder: FAILED **");
    end
    $finish;
  end

endmodule

@@ quadrature_knob_decoder.f @@
hw/rtl/qkd_pkg.sv
hw/rtl/qkd_phase.sv
hw/rtl/quadrature_knob_decoder.sv
sim/tb_quadrature_knob_decoder.sv
